/* design/led_brightness_fader_top_macros.svh */
// Assertion macros shared by the fader checker.
// Each macro expands to one labeled concurrent assertion on clk, gated by rst_n.
`ifndef LED_BRIGHTNESS_FADER_TOP_MACROS_SVH
`define LED_BRIGHTNESS_FADER_TOP_MACROS_SVH

// same-cycle implication
`define LBF_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LBF_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/lbf_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the LED brightness fader.
// No dependencies; used by all fader modules.
package lbf_pkg;

  localparam int unsigned NUM_LEDS_DEF = 4;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned FM_W    = 2;
  localparam int unsigned LVL_W   = 7;
  localparam int unsigned PWM_W   = 16;

  // opcodes
  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_TGT  = 2'd1;
  localparam logic [OP_W-1:0] OP_MODE = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;  // unused, answers like a write

  // fade modes
  localparam logic [FM_W-1:0] FM_BOTH  = 2'd0;
  localparam logic [FM_W-1:0] FM_RISE  = 2'd1;
  localparam logic [FM_W-1:0] FM_FALL  = 2'd2;
  localparam logic [FM_W-1:0] FM_STEEP = 2'd3;

  // register byte addresses
  localparam logic [1:0] ADDR_PWM_PERIOD = 2'd0;

  localparam logic [LVL_W-1:0]   LVL_MAX  = 7'd100;
  localparam logic [LEVEL_W-1:0] LVL_MAX8 = 8'd100;
  localparam logic [LEVEL_W-1:0] FOLD_MAX = 8'd200;

  localparam logic [PWM_W-1:0] PERIOD_RST = 16'd100;

  // floor(p / 100) = (p * DIV_RECIP) >> DIV_SHIFT, exact for p < 2**23
  localparam int unsigned PROD_W    = LVL_W + PWM_W;
  localparam int unsigned RECIP_W   = 24;
  localparam int unsigned QP_W      = PROD_W + RECIP_W;
  localparam int unsigned DIV_SHIFT = 30;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 24'd10737419;

  typedef struct packed {
    logic idle;
    logic walk;
    logic mul;
    logic div;
    logic fin;
  } lbf_cmd_t;

  typedef struct packed {
    logic walk_last;
  } lbf_stat_t;

endpackage

/* design/lbf_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for the fader: walks the LED table on a tick, then runs the width map.
// Depends on lbf_pkg.
module lbf_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lbf_pkg::OP_W-1:0]    in_opcode,
  input  lbf_pkg::lbf_stat_t          stat,
  output lbf_pkg::lbf_cmd_t           cmd,
  output logic                        busy
);
  import lbf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (start && in_opcode == OP_TICK) state_nxt = ST_WALK;
      ST_WALK:  if (stat.walk_last) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_DIV;
      ST_DIV:   state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd.idle = (state_r == ST_IDLE);
  assign cmd.walk = (state_r == ST_WALK);
  assign cmd.mul  = (state_r == ST_MUL);
  assign cmd.div  = (state_r == ST_DIV);
  assign cmd.fin  = (state_r == ST_DONE);
  assign busy     = (state_r != ST_IDLE);

endmodule

/* design/lbf_datapath.sv */
`timescale 1ns / 1ps
// Fader datapath: per-LED tables, step logic, width map and result registers.
// Depends on lbf_pkg; driven by lbf_ctrl.
module lbf_datapath #(
  parameter int unsigned NUM_LEDS = lbf_pkg::NUM_LEDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lbf_pkg::lbf_cmd_t             cmd,
  output lbf_pkg::lbf_stat_t            stat,
  input  logic                          start,
  input  logic [lbf_pkg::OP_W-1:0]      in_opcode,
  input  logic [lbf_pkg::IDX_W-1:0]     in_led_index,
  input  logic [lbf_pkg::LEVEL_W-1:0]   in_level,
  input  logic [lbf_pkg::FM_W-1:0]      in_fade_mode,
  input  logic [lbf_pkg::PWM_W-1:0]     pwm_period,
  output logic                          out_valid,
  output logic [lbf_pkg::PWM_W-1:0]     out_pwm_width,
  output logic                          out_pwm_changed,
  output logic [lbf_pkg::LVL_W-1:0]     out_led0_level
);
  import lbf_pkg::*;

  localparam int unsigned AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

  // tables
  logic [LVL_W-1:0] bri_mem  [NUM_LEDS];
  logic [LVL_W-1:0] tgt_mem  [NUM_LEDS];
  logic [FM_W-1:0]  mode_mem [NUM_LEDS];
  logic [NUM_LEDS-1:0] bri_vld_r, tgt_vld_r, mode_vld_r;

  logic [AW-1:0]    cnt_r;
  logic             rd_vld_r;
  logic [AW-1:0]    rd_addr_r;
  logic [LVL_W-1:0] b_rd_r, t_rd_r;
  logic [FM_W-1:0]  m_rd_r;
  logic             b_ok_r, t_ok_r, m_ok_r;

  logic [LVL_W-1:0] cur_b, cur_t, new_b, new_t, b_up, b_dn;
  logic [FM_W-1:0]  cur_m;

  logic             acc, wr_op, in_range;
  logic [6:0]       idx_ext;
  logic [AW-1:0]    wr_idx;
  logic [LEVEL_W-1:0] lvl_sat, tgt_fold8;
  logic [LVL_W-1:0] tgt_fold, start_lvl;

  logic [LVL_W-1:0] led0_r, led0_nxt;
  logic [PWM_W-1:0] fs, width, q_r, last_width_r;
  logic [PROD_W-1:0] prod_r;
  logic [QP_W-1:0]  qprod;

  logic             out_valid_r;
  logic [PWM_W-1:0] out_width_r;
  logic             out_changed_r;
  logic [LVL_W-1:0] out_level_r;

  // input decode
  assign acc      = start & cmd.idle;
  assign idx_ext  = {5'b0, in_led_index};
  assign in_range = (idx_ext < 7'(NUM_LEDS));
  assign wr_idx   = idx_ext[AW-1:0];
  assign wr_op    = acc && in_range && (in_opcode == OP_TGT || in_opcode == OP_MODE);

  assign lvl_sat   = (in_level > FOLD_MAX) ? FOLD_MAX : in_level;
  assign tgt_fold8 = (lvl_sat > LVL_MAX8) ? 8'(FOLD_MAX - lvl_sat) : lvl_sat;
  assign tgt_fold  = tgt_fold8[LVL_W-1:0];
  assign start_lvl = (in_level > LVL_MAX8) ? LVL_MAX : in_level[LVL_W-1:0];

  // walk counter and table read
  assign stat.walk_last = (cnt_r == AW'(NUM_LEDS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      cnt_r    <= cmd.walk ? AW'(cnt_r + 1'b1) : '0;
      rd_vld_r <= cmd.walk;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk) begin
      rd_addr_r <= cnt_r;
      b_rd_r    <= bri_mem[cnt_r];
      t_rd_r    <= tgt_mem[cnt_r];
      m_rd_r    <= mode_mem[cnt_r];
      b_ok_r    <= bri_vld_r[cnt_r];
      t_ok_r    <= tgt_vld_r[cnt_r];
      m_ok_r    <= mode_vld_r[cnt_r];
    end
  end

  // never-written entries read as zero
  assign cur_b = b_ok_r ? b_rd_r : '0;
  assign cur_t = t_ok_r ? t_rd_r : '0;
  assign cur_m = m_ok_r ? m_rd_r : FM_BOTH;

  assign b_up = (cur_b < LVL_MAX) ? LVL_W'(cur_b + 1'b1) : cur_b;
  assign b_dn = (cur_b != '0) ? LVL_W'(cur_b - 1'b1) : cur_b;

  always_comb begin
    new_b = cur_b;
    new_t = cur_t;
    case (cur_m)
      FM_BOTH: begin
        if (cur_t > cur_b) new_b = b_up;
        else if (cur_t < cur_b) new_b = b_dn;
      end
      FM_RISE: begin
        new_b = b_up;
        if (cur_t < b_up) begin
          new_b = cur_t;
          new_t = LVL_MAX;
        end
      end
      FM_FALL: begin
        new_b = b_dn;
        if (cur_t > b_dn) begin
          new_b = cur_t;
          new_t = '0;
        end
      end
      default: new_b = cur_t;
    endcase
  end

  // table write: tick write-back or host write
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      bri_mem[rd_addr_r] <= new_b;
      tgt_mem[rd_addr_r] <= new_t;
    end else if (wr_op) begin
      if (in_opcode == OP_TGT) begin
        tgt_mem[wr_idx] <= tgt_fold;
      end else begin
        bri_mem[wr_idx]  <= start_lvl;
        mode_mem[wr_idx] <= in_fade_mode;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bri_vld_r  <= '0;
      tgt_vld_r  <= '0;
      mode_vld_r <= '0;
    end else if (rd_vld_r) begin
      bri_vld_r[rd_addr_r] <= 1'b1;
      tgt_vld_r[rd_addr_r] <= 1'b1;
    end else if (wr_op) begin
      if (in_opcode == OP_TGT) begin
        tgt_vld_r[wr_idx] <= 1'b1;
      end else begin
        bri_vld_r[wr_idx]  <= 1'b1;
        mode_vld_r[wr_idx] <= 1'b1;
      end
    end
  end

  // shadow of LED 0 brightness
  always_comb begin
    led0_nxt = led0_r;
    if (rd_vld_r && rd_addr_r == '0) begin
      led0_nxt = new_b;
    end else if (wr_op && in_opcode == OP_MODE && wr_idx == '0) begin
      led0_nxt = start_lvl;
    end
  end

  // width map: fs - floor(led0 * fs / 100)
  assign fs    = (pwm_period == '0) ? '0 : PWM_W'(pwm_period - 1'b1);
  assign qprod = QP_W'(prod_r) * QP_W'(DIV_RECIP);
  assign width = PWM_W'(fs - q_r);

  always_ff @(posedge clk) begin
    if (cmd.mul) prod_r <= PROD_W'(led0_r) * PROD_W'(fs);
    if (cmd.div) q_r <= qprod[DIV_SHIFT +: PWM_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led0_r       <= '0;
      last_width_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      led0_r      <= led0_nxt;
      out_valid_r <= cmd.fin || (acc && in_opcode != OP_TICK);
      if (cmd.fin) last_width_r <= width;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_width_r   <= width;
      out_changed_r <= (width != last_width_r);
      out_level_r   <= led0_r;
    end else if (acc && in_opcode != OP_TICK) begin
      out_width_r   <= last_width_r;
      out_changed_r <= 1'b0;
      out_level_r   <= led0_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pwm_width   = out_width_r;
  assign out_pwm_changed = out_changed_r;
  assign out_led0_level  = out_level_r;

endmodule

/* design/led_brightness_fader_top.sv */
`timescale 1ns / 1ps
// LED brightness fader, top level: APB register, sequencer and datapath.
// Depends on lbf_pkg, lbf_ctrl and lbf_datapath.
//
// Usage:
//  - Command channel: drive start with in_opcode, in_led_index, in_level and
//    in_fade_mode; the item is taken at an edge where start is high and busy
//    is low.
//  - Target and mode writes (and the unused opcode) keep busy low, so one can
//    be issued every cycle. The result strobe out_valid rises in the cycle
//    after the transfer.
//  - A tick walks the LED table one entry per cycle (read one entry while the
//    previous one is written back), then runs the width map: one multiply,
//    one reciprocal multiply for the divide by 100, one subtract. busy stays
//    high throughout, and the result strobe comes in the cycle busy falls.
//  - Results are shown for exactly one cycle with out_valid; the receiver
//    cannot stall, so no backpressure path exists.
//  - pwm_period is written over APB at byte address 0 while the block is
//    idle; reads return it zero-extended to 32 bits. pready is tied high.
//  - Reset (rst_n low, synchronous) zeroes all brightness, targets, modes and
//    the last width, and sets pwm_period to 100. No clearing pass is needed.
module led_brightness_fader_top #(
  parameter int unsigned NUM_LEDS = lbf_pkg::NUM_LEDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [lbf_pkg::OP_W-1:0]      in_opcode,
  input  logic [lbf_pkg::IDX_W-1:0]     in_led_index,
  input  logic [lbf_pkg::LEVEL_W-1:0]   in_level,
  input  logic [lbf_pkg::FM_W-1:0]      in_fade_mode,
  // result channel
  output logic                          out_valid,
  output logic [lbf_pkg::PWM_W-1:0]     out_pwm_width,
  output logic                          out_pwm_changed,
  output logic [lbf_pkg::LVL_W-1:0]     out_led0_level,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [1:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import lbf_pkg::*;

  lbf_cmd_t         cmd;
  lbf_stat_t        stat;
  logic [PWM_W-1:0] period_r;
  logic             cfg_wr;

  // register file: only pwm_period at address 0
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr == ADDR_PWM_PERIOD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RST;
    end else if (cfg_wr) begin
      period_r <= pwdata[PWM_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_PWM_PERIOD) ? {{(32 - PWM_W){1'b0}}, period_r} : '0;

  lbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  lbf_datapath #(
    .NUM_LEDS (NUM_LEDS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .start           (start),
    .in_opcode       (in_opcode),
    .in_led_index    (in_led_index),
    .in_level        (in_level),
    .in_fade_mode    (in_fade_mode),
    .pwm_period      (period_r),
    .out_valid       (out_valid),
    .out_pwm_width   (out_pwm_width),
    .out_pwm_changed (out_pwm_changed),
    .out_led0_level  (out_led0_level)
  );

endmodule

/* design/lbf_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the fader, bound to the top level.
// Depends on lbf_pkg and led_brightness_fader_top_macros.svh.
`include "led_brightness_fader_top_macros.svh"

module lbf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [lbf_pkg::OP_W-1:0]      in_opcode,
  input logic                          out_valid,
  input logic [lbf_pkg::LVL_W-1:0]     out_led0_level
);
  import lbf_pkg::*;

  // a write transfer answers in the next cycle
  `LBF_ASSERT_NXT(a_wr_resp, start && !busy && in_opcode != OP_TICK, out_valid, "write without result")
  // a tick transfer occupies the block
  `LBF_ASSERT_NXT(a_tick_busy, start && !busy && in_opcode == OP_TICK, busy, "tick did not start")
  // tick result comes exactly as busy drops
  `LBF_ASSERT_NOW(a_tick_resp, $fell(busy), out_valid, "tick ended without result")
  // brightness never leaves full scale
  `LBF_ASSERT_NOW(a_level_rng, out_valid, out_led0_level <= LVL_MAX, "LED 0 level above full scale")

endmodule

bind led_brightness_fader_top lbf_checker u_lbf_checker (.*);

/* tb/tb_led_brightness_fader_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for led_brightness_fader_top: a directed table, then random
// command bursts over several pwm_period settings, scored by typed rows or a predictor.
// Depends on lbf_pkg and led_brightness_fader_top.
module tb_led_brightness_fader_top;
  import lbf_pkg::*;

  localparam int unsigned NLED = NUM_LEDS_DEF;

  localparam int unsigned RAND_PHASES   = 8;
  localparam int unsigned ITEMS_PER_PH  = 190;

  typedef struct packed {
    logic [PWM_W-1:0] width;
    logic             changed;
    logic [LVL_W-1:0] level;
  } fader_res_t;

  // one directed command, optionally preceded by a period write
  typedef struct packed {
    logic              cfg_en;
    logic [PWM_W-1:0]  cfg_val;
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic [LEVEL_W-1:0] lvl;
    logic [FM_W-1:0]   fm;
    logic              chk;
    fader_res_t        want;
  } stim_row_t;

  localparam fader_res_t NO_RES = '0;

  // Typed results only where obvious: right after reset the width is 99 at period 100
  // and nothing but a tick moves it. Everything else goes to the predictor.
  localparam stim_row_t DIR_ROWS [0:25] = '{
    '{1'b0, 16'd0,     OP_TICK, 2'd0, 8'd0,   FM_BOTH,  1'b1, '{16'd99, 1'b1, 7'd0}},
    '{1'b0, 16'd0,     OP_NONE, 2'd3, 8'd255, FM_STEEP, 1'b1, '{16'd99, 1'b0, 7'd0}},
    '{1'b0, 16'd0,     OP_TGT,  2'd0, 8'd255, FM_BOTH,  1'b1, '{16'd99, 1'b0, 7'd0}},
    '{1'b0, 16'd0,     OP_TGT,  2'd0, 8'd201, FM_BOTH,  1'b1, '{16'd99, 1'b0, 7'd0}},
    '{1'b0, 16'd0,     OP_MODE, 2'd0, 8'd255, FM_STEEP, 1'b1, '{16'd99, 1'b0, 7'd100}},
    '{1'b0, 16'd0,     OP_TGT,  2'd0, 8'd150, FM_BOTH,  1'b1, '{16'd99, 1'b0, 7'd100}},
    '{1'b0, 16'd0,     OP_TICK, 2'd0, 8'd0,   FM_BOTH,  1'b0, NO_RES},
    '{1'b0, 16'd0,     OP_TGT,  2'd1, 8'd100, FM_BOTH,  1'b0, NO_RES},
    '{1'b0, 16'd0,     OP_TGT,  2'd2, 8'd101, FM_BOTH,  1'b0, NO_RES},
    '{1'b0, 16'd0,     OP_MODE, 2'd0, 8'd100, FM_RISE,  1'b0, NO_RES},
    '{1'b0, 16'd0,     OP_TICK, 2'd0, 8'd0,   FM_BOTH,  1'b0, NO_RES},
    '{1'b0, 16'd0,     OP_MODE, 2'd0, 8'd0,   FM_FALL,  1'b0, NO_RES},
    '{1'b0, 16'd0,     OP_TICK, 2'd0, 8'd0,   FM_BOTH,  1'b0, NO_RES},
    '{1'b0, 16'd0,     OP_TICK, 2'd0, 8'd0,   FM_BOTH,  1'b0, NO_RES},
    '{1'b0, 16'd0,     OP_MODE, 2'd0, 8'd101, FM_BOTH,  1'b0, NO_RES},
    '{1'b0, 16'd0,     OP_TGT,  2'd0, 8'd200, FM_BOTH,  1'b0, NO_RES},
    '{1'b0, 16'd0,     OP_TICK, 2'd0, 8'd0,   FM_BOTH,  1'b0, NO_RES},
    '{1'b0, 16'd0,     OP_TGT,  2'd0, 8'd100, FM_BOTH,  1'b0, NO_RES},
    '{1'b0, 16'd0,     OP_TICK, 2'd0, 8'd0,   FM_BOTH,  1'b0, NO_RES},
    '{1'b0, 16'd0,     OP_MODE, 2'd1, 8'd37,  FM_FALL,  1'b0, NO_RES},
    '{1'b0, 16'd0,     OP_MODE, 2'd2, 8'd64,  FM_RISE,  1'b0, NO_RES},
    '{1'b0, 16'd0,     OP_MODE, 2'd3, 8'd12,  FM_STEEP, 1'b0, NO_RES},
    // tiny and maximal periods: at 0 and 1 full scale collapses to zero
    '{1'b1, 16'd0,     OP_TICK, 2'd0, 8'd0,   FM_BOTH,  1'b0, NO_RES},
    '{1'b1, 16'd1,     OP_TICK, 2'd0, 8'd0,   FM_BOTH,  1'b0, NO_RES},
    '{1'b1, 16'd65535, OP_TICK, 2'd0, 8'd0,   FM_BOTH,  1'b0, NO_RES},
    '{1'b1, 16'd2,     OP_TICK, 2'd0, 8'd0,   FM_BOTH,  1'b0, NO_RES}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [OP_W-1:0]    in_opcode;
  logic [IDX_W-1:0]   in_led_index;
  logic [LEVEL_W-1:0] in_level;
  logic [FM_W-1:0]    in_fade_mode;
  logic               out_valid;
  logic [PWM_W-1:0]   out_pwm_width;
  logic               out_pwm_changed;
  logic [LVL_W-1:0]   out_led0_level;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predictor state
  logic [LVL_W-1:0] led_bright [NLED];
  logic [LVL_W-1:0] led_target [NLED];
  logic [FM_W-1:0]  led_mode   [NLED];
  logic [PWM_W-1:0] last_pwm_w;
  logic [PWM_W-1:0] period_q;

  fader_res_t pending_res [$];
  int         err_cnt;

  // typed expectation of the command now on the bus
  logic       row_chk;
  fader_res_t row_want;

  led_brightness_fader_top dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_led_index(in_led_index),
    .in_level(in_level), .in_fade_mode(in_fade_mode),
    .out_valid(out_valid), .out_pwm_width(out_pwm_width),
    .out_pwm_changed(out_pwm_changed), .out_led0_level(out_led0_level),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
  endtask

  // Applies one command to the predictor state and returns the result it reports.
  function automatic fader_res_t fader_advance(input logic [OP_W-1:0] op,
                                               input logic [IDX_W-1:0] idx,
                                               input logic [LEVEL_W-1:0] lvl,
                                               input logic [FM_W-1:0] fm);
    fader_res_t r;
    logic [LVL_W-1:0] b;
    logic [LVL_W-1:0] t;
    logic [LEVEL_W-1:0] v;
    int unsigned fs;
    int unsigned scaled;
    logic [PWM_W-1:0] w;
    r.width   = last_pwm_w;
    r.changed = 1'b0;
    case (op)
      OP_TICK: begin
        for (int k = 0; k < NLED; k++) begin
          b = led_bright[k];
          t = led_target[k];
          case (led_mode[k])
            FM_BOTH: begin
              if (t > b) b = b + 1'b1;
              else if (t < b) b = b - 1'b1;
            end
            FM_RISE: begin
              if (b < LVL_MAX) b = b + 1'b1;
              if (t < b) begin
                b = t;
                t = LVL_MAX;
              end
            end
            FM_FALL: begin
              if (b > 0) b = b - 1'b1;
              if (t > b) begin
                b = t;
                t = '0;
              end
            end
            default: b = t;
          endcase
          led_bright[k] = b;
          led_target[k] = t;
        end
        fs = (period_q == 0) ? 0 : int'(period_q) - 1;
        scaled = (int'(led_bright[0]) * fs) / 100;
        w = PWM_W'(fs - scaled);
        r.width = w;
        if (w != last_pwm_w) begin
          r.changed  = 1'b1;
          last_pwm_w = w;
        end
      end
      OP_TGT: begin
        if (idx < NLED) begin
          v = (lvl > FOLD_MAX) ? FOLD_MAX : lvl;
          if (v > LVL_MAX8) v = FOLD_MAX - v;   // fold above full brightness
          led_target[idx] = v[LVL_W-1:0];
        end
      end
      OP_MODE: begin
        if (idx < NLED) begin
          v = (lvl > LVL_MAX8) ? LVL_MAX8 : lvl;
          led_mode[idx]   = fm;
          led_bright[idx] = v[LVL_W-1:0];
        end
      end
      default: ;  // unused opcode leaves everything alone
    endcase
    r.level = led_bright[0];
    return r;
  endfunction

  // Scoreboard: results are scored first, then the transfer of this edge is predicted,
  // so a result can never be matched against an item taken at the same edge.
  always @(posedge clk) begin
    fader_res_t got;
    fader_res_t want;
    fader_res_t calc;
    if (rst_n) begin
      if (out_valid) begin
        got = '{out_pwm_width, out_pwm_changed, out_led0_level};
        if (pending_res.size() == 0) begin
          flag_mismatch("result with none pending, width", 0, got.width);
        end else begin
          want = pending_res.pop_front();
          if (got.width != want.width)
            flag_mismatch("pwm_width", want.width, got.width);
          if (got.changed != want.changed)
            flag_mismatch("pwm_changed", want.changed, got.changed);
          if (got.level != want.level)
            flag_mismatch("led0_level", want.level, got.level);
        end
      end
      if (start && !busy) begin
        calc = fader_advance(in_opcode, in_led_index, in_level, in_fade_mode);
        pending_res.push_back(row_chk ? row_want : calc);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer with
  // start still high, so back-to-back commands keep it asserted.
  task automatic issue_cmd(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [LEVEL_W-1:0] lvl, input logic [FM_W-1:0] fm,
                           input logic chk, input fader_res_t want);
    row_chk      = chk;
    row_want     = want;
    start        <= 1'b1;
    in_opcode    <= op;
    in_led_index <= idx;
    in_level     <= lvl;
    in_fade_mode <= fm;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Stops the sender and waits for every outstanding result.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // APB write of pwm_period while idle, then a read-back check.
  task automatic set_period(input logic [PWM_W-1:0] val);
    drain_results();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_PWM_PERIOD;
    pwdata  <= {16'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    period_q = val;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {16'd0, val})
      flag_mismatch("pwm_period read-back", val, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Levels lean toward the useful 0..100 band, with the fold and saturation edges
  // and the full byte range mixed in.
  function automatic logic [LEVEL_W-1:0] pick_level();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return LEVEL_W'($urandom_range(0, 100));
    if (r < 85) return LEVEL_W'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd100;
      2:       return 8'd101;
      3:       return 8'd200;
      4:       return 8'd201;
      default: return 8'd255;
    endcase
  endfunction

  initial begin
    logic [PWM_W-1:0]   per;
    logic [OP_W-1:0]    op;
    logic [IDX_W-1:0]   idx;
    logic [LEVEL_W-1:0] lvl;
    logic [FM_W-1:0]    fm;
    int unsigned sent;
    int unsigned burst;
    int unsigned sel;

    err_cnt      = 0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_opcode    = OP_TICK;
    in_led_index = '0;
    in_level     = '0;
    in_fade_mode = FM_BOTH;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = ADDR_PWM_PERIOD;
    pwdata       = '0;
    row_chk      = 1'b0;
    row_want     = NO_RES;
    for (int k = 0; k < NLED; k++) begin
      led_bright[k] = '0;
      led_target[k] = '0;
      led_mode[k]   = FM_BOTH;
    end
    last_pwm_w = '0;
    period_q   = PERIOD_RST;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table; first write the reset value of pwm_period and check its read-back
    set_period(PERIOD_RST);
    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].cfg_en) set_period(DIR_ROWS[i].cfg_val);
      issue_cmd(DIR_ROWS[i].op, DIR_ROWS[i].idx, DIR_ROWS[i].lvl, DIR_ROWS[i].fm,
                DIR_ROWS[i].chk, DIR_ROWS[i].want);
    end

    // random phases, one period setting each
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: per = PERIOD_RST;
        1: per = 16'd2;
        2: per = 16'hFFFF;
        3: per = PWM_W'($urandom_range(2, 65535));
        4: per = 16'd1;
        5: per = PWM_W'($urandom_range(2, 400));
        6: per = 16'd0;
        default: per = PWM_W'($urandom_range(100, 2000));
      endcase
      set_period(per);
      sent = 0;
      while (sent < ITEMS_PER_PH) begin
        burst = $urandom_range(1, 16);
        if (burst > ITEMS_PER_PH - sent) burst = ITEMS_PER_PH - sent;
        repeat (burst) begin
          sel = $urandom_range(0, 99);
          // LED 0 is the only one visible at the outputs, so it gets at least half the writes
          idx = $urandom_range(0, 1) ? 2'd0 : IDX_W'($urandom_range(0, NLED - 1));
          lvl = pick_level();
          fm  = FM_W'($urandom_range(0, 3));
          if (sel < 40) op = OP_TICK;
          else if (sel < 70) op = OP_TGT;
          else if (sel < 95) op = OP_MODE;
          else op = OP_NONE;
          issue_cmd(op, idx, lvl, fm, 1'b0, NO_RES);
          sent++;
        end
        // gaps land anywhere, including mid-tick; some bursts run straight on
        if ($urandom_range(0, 49) == 0) begin
          drain_results();
        end else if ($urandom_range(0, 9) >= 3) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 12)) @(negedge clk);
        end
      end
    end

    drain_results();
    repeat (12) @(negedge clk);  // catch stray strobes after the last tick
    if (err_cnt == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
